### design/ihpc_pkg.sv
// Package for the IR obstacle heading PI controller.
// Holds widths, fixed-point constants, register indexes and the CORDIC table.
// No dependencies.
`default_nettype none
package ihpc_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_PROP     = 3'd0,
		CFG_GAIN_INTEGRAL = 3'd1,
		CFG_BASE_SPEED    = 3'd2,
		CFG_DUTY_LIMIT    = 3'd3,
		CFG_FWD_OFFSET    = 3'd4,
		CFG_SIDE_OFFSET   = 3'd5
	} cfg_idx_t;

	localparam int ANG_W      = 38;
	localparam int VEC_W      = 50;
	localparam int MUL_A_W    = 32;
	localparam int MUL_B_W    = 24;
	localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
	localparam int DUTY_N_W   = 58;
	localparam int ATAN_IDX_W = 5;
	localparam int DUTY_W     = 15;
	localparam int DIV_IN_W   = 17;

	localparam logic signed [ANG_W-1:0] Q30_PI      = 38'sd3373259426;
	localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 38'sd1686629713;
	localparam logic signed [ANG_W-1:0] Q30_TWO_PI  = 38'sd6746518852;
	localparam logic signed [VEC_W-1:0] CORDIC_GAIN = 50'sd652032874;

	localparam logic signed [MUL_A_W-1:0] RECIP_1000 = 32'sd4294968;
	localparam int                        RECIP_1000_SH = 32;
	localparam logic signed [MUL_A_W-1:0] RECIP_7 = 32'sd149797;
	localparam int                        RECIP_7_SH = 20;
	localparam logic signed [MUL_B_W-1:0] LEG_SCALE = 24'sd707;
	localparam logic [DUTY_W-1:0]         DUTY_MAX = 15'd16383;

	function automatic logic signed [ANG_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
		logic signed [ANG_W-1:0] r;
		unique case (idx)
			5'd0:  r = 38'sd843314856;
			5'd1:  r = 38'sd497837829;
			5'd2:  r = 38'sd263043836;
			5'd3:  r = 38'sd133525158;
			5'd4:  r = 38'sd67021686;
			5'd5:  r = 38'sd33543515;
			5'd6:  r = 38'sd16771754;
			5'd7:  r = 38'sd8388437;
			5'd8:  r = 38'sd4194282;
			5'd9:  r = 38'sd2097149;
			5'd10: r = 38'sd1048575;
			5'd11: r = 38'sd524287;
			5'd12: r = 38'sd262143;
			5'd13: r = 38'sd131071;
			5'd14: r = 38'sd65535;
			5'd15: r = 38'sd32767;
			5'd16: r = 38'sd16383;
			5'd17: r = 38'sd8191;
			5'd18: r = 38'sd4095;
			5'd19: r = 38'sd2047;
			5'd20: r = 38'sd1023;
			5'd21: r = 38'sd511;
			5'd22: r = 38'sd255;
			5'd23: r = 38'sd127;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Applies the magnitude clamp and the sign to one duty value.
	function automatic logic signed [DUTY_W-1:0] clamp_duty(input logic [DUTY_W-1:0] q,
		input logic [DUTY_W-1:0] lim, input logic neg);
		logic [DUTY_W-1:0] m;
		m = (q > lim) ? lim : q;
		return neg ? -signed'(m) : signed'(m);
	endfunction

endpackage
`default_nettype wire

### design/ihpc_if.sv
// Channel interfaces of the heading controller: measurement input and duty output.
// Valid/ready handshake; no dependencies.
`default_nettype none
interface ihpc_meas_if;
	logic               valid;
	logic               ready;
	logic        [11:0] dist_left;
	logic        [11:0] dist_right;
	logic signed [15:0] pose_x;
	logic signed [15:0] pose_y;
	logic signed [15:0] pose_theta;

	modport source (output valid, dist_left, dist_right, pose_x, pose_y, pose_theta,
		input ready);
	modport sink (input valid, dist_left, dist_right, pose_x, pose_y, pose_theta,
		output ready);
endinterface

interface ihpc_drive_if;
	logic               valid;
	logic               ready;
	logic signed [14:0] duty_left;
	logic signed [14:0] duty_right;

	modport source (output valid, duty_left, duty_right, input ready);
	modport sink (input valid, duty_left, duty_right, output ready);
endinterface
`default_nettype wire

### design/ihpc_mul.sv
// Shared signed multiplier with a registered product for the heading controller.
// Depends on ihpc_pkg.
`default_nettype none
module ihpc_mul
	import ihpc_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic signed [MUL_A_W-1:0] a,
	input  wire logic signed [MUL_B_W-1:0] b,
	output logic signed [MUL_P_W-1:0]      p
);

	always_ff @(posedge clk) begin
		if (en) begin
			p <= MUL_P_W'(a) * MUL_P_W'(b);
		end
	end

endmodule
`default_nettype wire

### design/ir_obstacle_heading_pi_controller_unit.sv
// Top level of the IR obstacle heading PI controller.
// Depends on ihpc_pkg, ihpc_if and ihpc_mul.
//
// Usage: one measurement transaction on meas (two IR distances and the pose)
// yields one transaction on drive (left and right duty). Registers are written
// through cfg_wr_en, cfg_index and cfg_data; the user must do this only while
// the block is idle, which the block itself does not enforce. A transaction is
// worked on by a sequencer around one multiplier and one CORDIC shift-add
// stage. The heading and the error each pass a wrap step that repeats until
// the angle is in range, and the vectoring CORDIC pass is skipped when the
// goal vector is zero.
// meas.ready is high only while the sequencer is idle, so one transaction is
// worked on at a time. The result waits in an output register; the next
// transaction is accepted while it waits, and the sequencer holds in its last
// step only if a new result is ready while the old one is still not taken.
// Reset clears the integrator, loads the register defaults and leaves drive
// empty.
`default_nettype none
module ir_obstacle_heading_pi_controller_unit
	import ihpc_pkg::*;
#(
	parameter int ANGLE_FRAC_BITS = 13,
	parameter int CORDIC_STEPS    = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	ihpc_meas_if.sink                  meas,
	ihpc_drive_if.source               drive
);

	localparam int TH_SHIFT = 30 - ANGLE_FRAC_BITS;
	localparam int SCALE_SH = ANGLE_FRAC_BITS + 8;
	localparam int STEP_W   = $clog2(CORDIC_STEPS);

	typedef enum logic [26:0] {
		S_IDLE     = 27'h0000001,
		S_TL       = 27'h0000002,
		S_TLD      = 27'h0000004,
		S_TR       = 27'h0000008,
		S_TRD      = 27'h0000010,
		S_SUMS     = 27'h0000020,
		S_WRAP_TH  = 27'h0000040,
		S_FOLD     = 27'h0000080,
		S_ROT      = 27'h0000100,
		S_TRIG     = 27'h0000200,
		S_M_CSX    = 27'h0000400,
		S_M_SSY    = 27'h0000800,
		S_M_SSX    = 27'h0001000,
		S_M_CSY    = 27'h0002000,
		S_ACC_Y    = 27'h0004000,
		S_VPREP    = 27'h0008000,
		S_VEC      = 27'h0010000,
		S_ERR      = 27'h0020000,
		S_WRAP_ERR = 27'h0040000,
		S_INTEG    = 27'h0080000,
		S_M_GP     = 27'h0100000,
		S_M_GI     = 27'h0200000,
		S_WSUM     = 27'h0400000,
		S_DUTY_L   = 27'h0800000,
		S_DUTY_R   = 27'h1000000,
		S_DIV_R    = 27'h2000000,
		S_DONE     = 27'h4000000
	} state_t;

	state_t state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;

	logic [19:0]        gain_prop_q;
	logic [15:0]        gain_int_q;
	logic [16:0]        base_speed_q;
	logic [14:0]        duty_limit_q;
	logic signed [10:0] fwd_q;
	logic signed [31:0] integ_q;

	logic [11:0]        dl_q, dr_q, tl_q;
	logic signed [15:0] px_q, py_q;
	logic signed [14:0] sx_q;
	logic signed [12:0] sy_q;
	logic signed [ANG_W-1:0] z_q, th_q;
	logic signed [VEC_W-1:0] x_q, y_q;
	logic                    flip_q;
	logic signed [31:0]      c_q, s_q, errq_q;
	logic signed [MUL_P_W-1:0] w_q;
	logic [DIV_IN_W-1:0]     vl_q, vr_q;
	logic                    nl_q, nr_q;
	logic [DUTY_W-1:0]       ql_q;
	logic signed [DUTY_W-1:0] duty_l_q, duty_r_q;

	logic                      mul_en;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] prod;

	logic                    step_last, pos, out_load;
	logic signed [VEC_W-1:0] xsh, ysh, cneg, sneg;
	logic signed [ANG_W-1:0] atan_v, errq_full;
	logic signed [32:0]      isum;
	logic signed [31:0]      isat;
	logic signed [DUTY_N_W-1:0] base_s, w14, n_duty, mag;
	logic [DUTY_N_W-1:0]     mag_sh;
	logic [DIV_IN_W-1:0]     v_duty;
	logic [DUTY_W-1:0]       lim;

	ihpc_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	assign meas.ready  = (state_q == S_IDLE);
	assign drive.valid = out_valid_q;
	assign drive.duty_left  = duty_l_q;
	assign drive.duty_right = duty_r_q;

	assign step_last = (step_q == STEP_W'(CORDIC_STEPS - 1));
	assign xsh       = x_q >>> step_q;
	assign ysh       = y_q >>> step_q;
	assign atan_v    = atan_q30(ATAN_IDX_W'(step_q));
	assign pos       = (state_q == S_ROT) ? !z_q[ANG_W-1] : !(y_q > 0);
	assign cneg      = flip_q ? -x_q : x_q;
	assign sneg      = flip_q ? -y_q : y_q;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || drive.ready);

	assign errq_full = z_q >>> TH_SHIFT;
	assign isum      = 33'(integ_q) + 33'(signed'(errq_full[31:0]));
	assign isat      = (isum[32] != isum[31]) ? (isum[32] ? 32'sh80000000 : 32'sh7fffffff)
	                                          : isum[31:0];

	assign base_s = DUTY_N_W'(signed'({1'b0, base_speed_q})) <<< SCALE_SH;
	assign w14    = (DUTY_N_W'(w_q) <<< 4) - (DUTY_N_W'(w_q) <<< 1);
	assign n_duty = (state_q == S_DUTY_R) ? base_s + w14 : base_s - w14;
	assign mag    = n_duty[DUTY_N_W-1] ? -n_duty : n_duty;
	assign mag_sh = unsigned'(mag) >> SCALE_SH;
	assign v_duty = (|mag_sh[DUTY_N_W-1:DIV_IN_W]) ? '1 : mag_sh[DIV_IN_W-1:0];
	assign lim    = (duty_limit_q > DUTY_MAX) ? DUTY_MAX : duty_limit_q;

	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		unique case (state_q)
			S_TL: begin
				mul_a = MUL_A_W'(signed'({1'b0, dl_q}));
				mul_b = LEG_SCALE;
			end
			S_TR: begin
				mul_a = MUL_A_W'(signed'({1'b0, dr_q}));
				mul_b = LEG_SCALE;
			end
			S_TLD, S_TRD: begin
				mul_a = RECIP_1000;
				mul_b = signed'({2'b00, prod[21:0]});
			end
			S_M_CSX: begin
				mul_a = c_q;
				mul_b = MUL_B_W'(sx_q);
			end
			S_M_SSY: begin
				mul_a = s_q;
				mul_b = MUL_B_W'(sy_q);
			end
			S_M_SSX: begin
				mul_a = s_q;
				mul_b = MUL_B_W'(sx_q);
			end
			S_M_CSY: begin
				mul_a = c_q;
				mul_b = MUL_B_W'(sy_q);
			end
			S_M_GP: begin
				mul_a = errq_q;
				mul_b = signed'({4'b0, gain_prop_q});
			end
			S_M_GI: begin
				mul_a = integ_q;
				mul_b = signed'({8'b0, gain_int_q});
			end
			S_DUTY_R: begin
				mul_a = RECIP_7;
				mul_b = signed'({7'b0, vl_q});
			end
			S_DIV_R: begin
				mul_a = RECIP_7;
				mul_b = signed'({7'b0, vr_q});
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:     if (meas.valid) state_d = S_TL;
			S_TL:       state_d = S_TLD;
			S_TLD:      state_d = S_TR;
			S_TR:       state_d = S_TRD;
			S_TRD:      state_d = S_SUMS;
			S_SUMS:     state_d = S_WRAP_TH;
			S_WRAP_TH:  if (!(z_q >= Q30_PI) && !(z_q < -Q30_PI)) state_d = S_FOLD;
			S_FOLD:     state_d = S_ROT;
			S_ROT:      if (step_last) state_d = S_TRIG;
			S_TRIG:     state_d = S_M_CSX;
			S_M_CSX:    state_d = S_M_SSY;
			S_M_SSY:    state_d = S_M_SSX;
			S_M_SSX:    state_d = S_M_CSY;
			S_M_CSY:    state_d = S_ACC_Y;
			S_ACC_Y:    state_d = S_VPREP;
			S_VPREP:    state_d = (x_q == '0 && y_q == '0) ? S_ERR : S_VEC;
			S_VEC:      if (step_last) state_d = S_ERR;
			S_ERR:      state_d = S_WRAP_ERR;
			S_WRAP_ERR: if (!(z_q > Q30_PI) && !(z_q <= -Q30_PI)) state_d = S_INTEG;
			S_INTEG:    state_d = S_M_GP;
			S_M_GP:     state_d = S_M_GI;
			S_M_GI:     state_d = S_WSUM;
			S_WSUM:     state_d = S_DUTY_L;
			S_DUTY_L:   state_d = S_DUTY_R;
			S_DUTY_R:   state_d = S_DIV_R;
			S_DIV_R:    state_d = S_DONE;
			S_DONE:     if (out_load) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			step_q       <= '0;
			out_valid_q  <= 1'b0;
			integ_q      <= '0;
			gain_prop_q  <= 20'd212480;
			gain_int_q   <= 16'd1434;
			base_speed_q <= 17'd35000;
			duty_limit_q <= 15'd11000;
			fwd_q        <= 11'sd50;
		end else begin
			state_q <= state_d;
			if (state_q == S_FOLD || state_q == S_VPREP) begin
				step_q <= '0;
			end else if (state_q == S_ROT || state_q == S_VEC) begin
				step_q <= step_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (drive.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_INTEG) begin
				integ_q <= isat;
			end
			if (cfg_wr_en) begin
				unique case (cfg_index)
					CFG_GAIN_PROP:     gain_prop_q  <= cfg_data;
					CFG_GAIN_INTEGRAL: gain_int_q   <= cfg_data[15:0];
					CFG_BASE_SPEED:    base_speed_q <= cfg_data[16:0];
					CFG_DUTY_LIMIT:    duty_limit_q <= cfg_data[14:0];
					CFG_FWD_OFFSET:    fwd_q        <= signed'(cfg_data[10:0]);
					// The lateral offset cancels in the summed goal vector, so it is not stored.
					CFG_SIDE_OFFSET:   ;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (meas.valid) begin
					dl_q <= meas.dist_left;
					dr_q <= meas.dist_right;
					px_q <= meas.pose_x;
					py_q <= meas.pose_y;
					z_q  <= ANG_W'(meas.pose_theta) <<< TH_SHIFT;
				end
			end
			S_TR: begin
				tl_q <= prod[RECIP_1000_SH +: 12];
			end
			S_SUMS: begin
				sx_q <= 15'(signed'({1'b0, tl_q})) + 15'(signed'({1'b0, prod[RECIP_1000_SH +: 12]}))
				        + (15'(fwd_q) <<< 1);
				sy_q <= signed'({1'b0, tl_q}) - signed'({1'b0, prod[RECIP_1000_SH +: 12]});
			end
			S_WRAP_TH: begin
				if (z_q >= Q30_PI) begin
					z_q <= z_q - Q30_TWO_PI;
				end else if (z_q < -Q30_PI) begin
					z_q <= z_q + Q30_TWO_PI;
				end else begin
					th_q <= z_q;
				end
			end
			S_FOLD: begin
				x_q <= CORDIC_GAIN;
				y_q <= '0;
				if (z_q > Q30_HALF_PI) begin
					z_q    <= z_q - Q30_PI;
					flip_q <= 1'b1;
				end else if (z_q < -Q30_HALF_PI) begin
					z_q    <= z_q + Q30_PI;
					flip_q <= 1'b1;
				end else begin
					flip_q <= 1'b0;
				end
			end
			S_ROT, S_VEC: begin
				x_q <= pos ? x_q - ysh : x_q + ysh;
				y_q <= pos ? y_q + xsh : y_q - xsh;
				z_q <= pos ? z_q - atan_v : z_q + atan_v;
			end
			S_TRIG: begin
				c_q <= cneg[31:0];
				s_q <= sneg[31:0];
				x_q <= VEC_W'(px_q) <<< 30;
				y_q <= VEC_W'(py_q) <<< 30;
			end
			S_M_SSY: x_q <= x_q + VEC_W'(prod);
			S_M_SSX: x_q <= x_q - VEC_W'(prod);
			S_M_CSY: y_q <= y_q + VEC_W'(prod);
			S_ACC_Y: y_q <= y_q + VEC_W'(prod);
			S_VPREP: begin
				if (x_q[VEC_W-1]) begin
					z_q <= y_q[VEC_W-1] ? -Q30_PI : Q30_PI;
					x_q <= -x_q;
					y_q <= -y_q;
				end else begin
					z_q <= '0;
				end
			end
			S_ERR: begin
				z_q <= z_q - th_q;
			end
			S_WRAP_ERR: begin
				if (z_q > Q30_PI) begin
					z_q <= z_q - Q30_TWO_PI;
				end else if (z_q <= -Q30_PI) begin
					z_q <= z_q + Q30_TWO_PI;
				end
			end
			S_INTEG: begin
				errq_q <= errq_full[31:0];
			end
			S_M_GI: begin
				w_q <= prod;
			end
			S_WSUM: begin
				w_q <= w_q + prod;
			end
			S_DUTY_L: begin
				vl_q <= v_duty;
				nl_q <= n_duty[DUTY_N_W-1];
			end
			S_DUTY_R: begin
				vr_q <= v_duty;
				nr_q <= n_duty[DUTY_N_W-1];
			end
			S_DIV_R: begin
				ql_q <= prod[RECIP_7_SH +: DUTY_W];
			end
			S_DONE: begin
				if (out_load) begin
					duty_l_q <= clamp_duty(ql_q, lim, nl_q);
					duty_r_q <= clamp_duty(prod[RECIP_7_SH +: DUTY_W], lim, nr_q);
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

### design/ihpc_checker.sv
// Port-level checker for the heading controller, bound to the top level.
// Depends on ihpc_pkg for the duty width; sees only the top-level ports.
`default_nettype none
module ihpc_checker
	import ihpc_pkg::*;
(
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     in_valid,
	input wire logic                     in_ready,
	input wire logic                     out_valid,
	input wire logic                     out_ready,
	input wire logic signed [DUTY_W-1:0] duty_left,
	input wire logic signed [DUTY_W-1:0] duty_right
);

	// A pending result stays offered until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("drive valid dropped without a transaction");

	// A stalled result keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(duty_left) && $stable(duty_right))
		else $error("drive payload changed while stalled");

	// One transaction is worked on at a time.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("measurement accepted while busy");

	// A result is only loaded in the sequencer's last step, so none can appear right after an acceptance.
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared right after acceptance");

	// The clamp keeps both duties inside the symmetric range.
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (duty_left != 15'sh4000) && (duty_right != 15'sh4000))
		else $error("duty outside clamp range");

endmodule

bind ir_obstacle_heading_pi_controller_unit ihpc_checker u_ihpc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (meas.valid),
	.in_ready   (meas.ready),
	.out_valid  (drive.valid),
	.out_ready  (drive.ready),
	.duty_left  (drive.duty_left),
	.duty_right (drive.duty_right)
);
`default_nettype wire
